FILE: rtl/edit_distance_engine_core_macros.svh
// ----------------------------------------------------------------------------
// edit distance engine assertion macros
// concurrent check wrappers, compiled out for synthesis
// ----------------------------------------------------------------------------
`ifndef EDIT_DISTANCE_ENGINE_CORE_MACROS_SVH
`define EDIT_DISTANCE_ENGINE_CORE_MACROS_SVH
`ifndef SYNTHESIS
// plain property, sampled on the rising clock edge, off during reset
`define EDC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("edc check failed");
// same-cycle implication
`define EDC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("edc check failed");
`else
`define EDC_ASSERT(label, clk, rst, prop)
`define EDC_ASSERT_IMP(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/edc_pkg.sv
// ----------------------------------------------------------------------------
// edc_pkg
// shared constants, request codes and controller/datapath handshake structs
// ----------------------------------------------------------------------------
`default_nettype none
package edc_pkg;

   // payload widths fixed by the word format
   localparam int FUNC_W    = 2;
   localparam int CHAR_W    = 8;
   localparam int DIST_BITS = 7;
   localparam int DIST_MAX  = 127;

   // parameter defaults
   localparam int DEF_MAX_LEN   = 64;
   localparam int DEF_CHAR_BITS = 8;

   // request function codes
   localparam logic [FUNC_W-1:0] FUNC_SRC = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TGT = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_RUN = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic append_src;
      logic append_tgt;
      logic start;
      logic row_init;
      logic col_step;
      logic emit;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic src_empty;
      logic tgt_empty;
      logic last_cell;
      logic last_row;
      logic out_free;
   } sts_type;

endpackage
`default_nettype wire

FILE: rtl/edc_if.sv
// ----------------------------------------------------------------------------
// edc channel interfaces
// valid/ready request and response channels of the edit distance engine
// ----------------------------------------------------------------------------
`default_nettype none
interface edc_req_if;
   logic                      valid;
   logic                      ready;
   logic [edc_pkg::FUNC_W-1:0] func;
   logic [edc_pkg::CHAR_W-1:0] char_value;

   modport source (output valid, output func, output char_value, input ready);
   modport sink   (input valid, input func, input char_value, output ready);
endinterface

interface edc_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [edc_pkg::DIST_BITS-1:0] distance;
   logic                         too_long;

   modport source (output valid, output distance, output too_long, input ready);
   modport sink   (input valid, input distance, input too_long, output ready);
endinterface
`default_nettype wire

FILE: rtl/edc_ctrl.sv
// ----------------------------------------------------------------------------
// edc_ctrl
// sequencer: accepts request words, walks the cost row over source rows and
// target columns, and hands the result to the response register
// ----------------------------------------------------------------------------
`default_nettype none
module edc_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   input  wire logic [edc_pkg::FUNC_W-1:0] req_func,
   output logic                            req_ready,
   input  wire edc_pkg::sts_type           sts,
   output edc_pkg::cmd_type                cmd
);
   import edc_pkg::*;
   `include "edit_distance_engine_core_macros.svh"

   localparam logic [1:0] ST_IDLE      = 2'd0;
   localparam logic [1:0] ST_ROW_START = 2'd1;
   localparam logic [1:0] ST_CELL      = 2'd2;
   localparam logic [1:0] ST_FINISH    = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and command decode
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_func)
                  FUNC_SRC: cmd.append_src = 1'b1;
                  FUNC_TGT: cmd.append_tgt = 1'b1;
                  FUNC_RUN: begin
                     if (sts.src_empty || sts.tgt_empty) begin
                        state_in = ST_FINISH;
                     end else begin
                        cmd.start = 1'b1;
                        state_in  = ST_ROW_START;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_ROW_START: begin
            cmd.row_init = 1'b1;
            state_in     = ST_CELL;
         end
         ST_CELL: begin
            cmd.col_step = 1'b1;
            if (sts.last_cell) begin
               state_in = sts.last_row ? ST_FINISH : ST_ROW_START;
            end
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // at most one datapath command per cycle
   `EDC_ASSERT(a_cmd_onehot, clock, reset, $onehot0(cmd))
   // a pending result holds the sequencer in finish
   `EDC_ASSERT(a_finish_hold, clock, reset,
      (state_ff == ST_FINISH && !sts.out_free) |=> state_ff == ST_FINISH)
   // a compute on two non-empty strings opens the first row
   `EDC_ASSERT(a_start_row, clock, reset, cmd.start |=> state_ff == ST_ROW_START)

endmodule
`default_nettype wire

FILE: rtl/edc_datapath.sv
// ----------------------------------------------------------------------------
// edc_datapath
// string stores, single cost row memory, one dp cell and the response register
// ----------------------------------------------------------------------------
`default_nettype none
module edc_datapath #(
   parameter int MAX_LEN   = edc_pkg::DEF_MAX_LEN,
   parameter int CHAR_BITS = edc_pkg::DEF_CHAR_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire edc_pkg::cmd_type              cmd,
   output edc_pkg::sts_type                   sts,
   input  wire logic [edc_pkg::CHAR_W-1:0]    char_value,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [edc_pkg::DIST_BITS-1:0]      rsp_distance,
   output logic                               rsp_too_long
);
   import edc_pkg::*;
   `include "edit_distance_engine_core_macros.svh"

   localparam int LEN_BITS   = $clog2(MAX_LEN + 1);
   localparam int ADDR_BITS  = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
   localparam int STORE_BITS = (CHAR_BITS < CHAR_W) ? CHAR_BITS : CHAR_W;
   localparam logic [LEN_BITS-1:0] LEN_FULL = LEN_BITS'(MAX_LEN);
   localparam logic [LEN_BITS-1:0] LEN_ONE  = LEN_BITS'(1);

   // memories
   logic [STORE_BITS-1:0] src_mem [0:MAX_LEN-1];
   logic [STORE_BITS-1:0] tgt_mem [0:MAX_LEN-1];
   logic [LEN_BITS-1:0]   row_mem [0:MAX_LEN-1];
   logic [STORE_BITS-1:0] src_q_ff;
   logic [STORE_BITS-1:0] tgt_q_ff;
   logic [LEN_BITS-1:0]   row_q_ff;

   logic [LEN_BITS-1:0]  src_len_ff, src_len_in;
   logic [LEN_BITS-1:0]  tgt_len_ff, tgt_len_in;
   logic                 ovf_ff, ovf_in;
   logic [LEN_BITS-1:0]  row_ff, row_in;
   logic [LEN_BITS-1:0]  col_ff, col_in;
   logic [LEN_BITS-1:0]  diag_ff, diag_in;
   logic [LEN_BITS-1:0]  left_ff, left_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DIST_BITS-1:0] rsp_dist_ff, rsp_dist_in;
   logic                 rsp_long_ff, rsp_long_in;

   logic [LEN_BITS-1:0]   col_next;
   logic [LEN_BITS-1:0]   row_m1;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [STORE_BITS-1:0] char_word;
   logic [LEN_BITS-1:0]   up_cost;
   logic [LEN_BITS-1:0]   min_a;
   logic [LEN_BITS-1:0]   min_b;
   logic [LEN_BITS-1:0]   cell_cost;
   logic [LEN_BITS-1:0]   dist_full;
   logic                  src_full;
   logic                  tgt_full;

   assign col_next  = col_ff + LEN_ONE;
   assign row_m1    = row_ff - LEN_ONE;
   assign rd_addr   = cmd.row_init ? '0 : col_next[ADDR_BITS-1:0];
   assign char_word = char_value[STORE_BITS-1:0];
   assign src_full  = (src_len_ff == LEN_FULL);
   assign tgt_full  = (tgt_len_ff == LEN_FULL);

   // string stores, written on append
   always_ff @(posedge clock) begin
      if (cmd.append_src && !src_full) begin
         src_mem[src_len_ff[ADDR_BITS-1:0]] <= char_word;
      end
      if (cmd.append_tgt && !tgt_full) begin
         tgt_mem[tgt_len_ff[ADDR_BITS-1:0]] <= char_word;
      end
   end

   // registered reads; source character held across the whole row
   always_ff @(posedge clock) begin
      if (cmd.row_init) begin
         src_q_ff <= src_mem[row_m1[ADDR_BITS-1:0]];
      end
      tgt_q_ff <= tgt_mem[rd_addr];
      row_q_ff <= row_mem[rd_addr];
   end

   // cost row write-back, one column per cycle
   always_ff @(posedge clock) begin
      if (cmd.col_step) begin
         row_mem[col_ff[ADDR_BITS-1:0]] <= cell_cost;
      end
   end

   // dp cell: first row above is the column index itself
   always_comb begin
      up_cost   = (row_ff == LEN_ONE) ? col_next : row_q_ff;
      min_a     = (diag_ff < left_ff) ? diag_ff : left_ff;
      min_b     = (min_a < up_cost) ? min_a : up_cost;
      cell_cost = (src_q_ff == tgt_q_ff) ? diag_ff : min_b + LEN_ONE;
   end

   // empty string: distance is the other length
   assign dist_full = (src_len_ff == '0 || tgt_len_ff == '0) ? (src_len_ff | tgt_len_ff)
                                                             : left_ff;

   // next values
   always_comb begin
      src_len_in   = src_len_ff;
      tgt_len_in   = tgt_len_ff;
      ovf_in       = ovf_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      diag_in      = diag_ff;
      left_in      = left_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_dist_in  = rsp_dist_ff;
      rsp_long_in  = rsp_long_ff;

      if (cmd.append_src) begin
         if (src_full) begin
            ovf_in = 1'b1;
         end else begin
            src_len_in = src_len_ff + LEN_ONE;
         end
      end
      if (cmd.append_tgt) begin
         if (tgt_full) begin
            ovf_in = 1'b1;
         end else begin
            tgt_len_in = tgt_len_ff + LEN_ONE;
         end
      end
      if (cmd.start) begin
         row_in = LEN_ONE;
      end
      if (cmd.row_init) begin
         left_in = row_ff;
         diag_in = row_m1;
         col_in  = '0;
      end
      if (cmd.col_step) begin
         left_in = cell_cost;
         diag_in = up_cost;
         col_in  = col_next;
         if (sts.last_cell && !sts.last_row) begin
            row_in = row_ff + LEN_ONE;
         end
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         rsp_long_in  = ovf_ff;
         if (32'(dist_full) > DIST_MAX) begin
            rsp_dist_in = DIST_BITS'(DIST_MAX);
         end else begin
            rsp_dist_in = DIST_BITS'(dist_full);
         end
         src_len_in = '0;
         tgt_len_in = '0;
         ovf_in     = 1'b0;
      end
   end

   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         src_len_ff   <= '0;
         tgt_len_ff   <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         src_len_ff   <= src_len_in;
         tgt_len_ff   <= tgt_len_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      row_ff      <= row_in;
      col_ff      <= col_in;
      diag_ff     <= diag_in;
      left_ff     <= left_in;
      rsp_dist_ff <= rsp_dist_in;
      rsp_long_ff <= rsp_long_in;
   end

   // status to the sequencer
   always_comb begin
      sts.src_empty = (src_len_ff == '0);
      sts.tgt_empty = (tgt_len_ff == '0);
      sts.last_cell = (col_next == tgt_len_ff);
      sts.last_row  = (row_ff == src_len_ff);
      sts.out_free  = !rsp_valid_ff || rsp_ready;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_distance = rsp_dist_ff;
   assign rsp_too_long = rsp_long_ff;

   // string lengths never pass the store depth
   `EDC_ASSERT(a_len_bound, clock, reset, src_len_ff <= LEN_FULL && tgt_len_ff <= LEN_FULL)
   // the sweep stays inside the loaded target
   `EDC_ASSERT_IMP(a_col_bound, clock, reset, cmd.col_step, col_ff < tgt_len_ff)
   // handing over a result clears both strings and the overflow mark
   `EDC_ASSERT(a_emit_clear, clock, reset,
      cmd.emit |=> (rsp_valid_ff && src_len_ff == '0 && tgt_len_ff == '0 && !ovf_ff))

endmodule
`default_nettype wire

FILE: rtl/edit_distance_engine_core.sv
// load words (append to source or target) are accepted one per cycle while the sequencer is idle.
// a compute word on strings of length m and n, both non-empty, runs a row set-up
// step and then one column per cycle for each of the m rows, then a finish step
// puts the result in the response register.
// with either string empty the sequencer goes straight to finish; an untaken result stalls.
// synchronous active-high reset clears lengths, overflow mark and response.
// ----------------------------------------------------------------------------
// edit_distance_engine_core
// levenshtein distance between a loaded source and target string
// ----------------------------------------------------------------------------
`default_nettype none
module edit_distance_engine_core #(
   parameter int MAX_LEN   = edc_pkg::DEF_MAX_LEN,
   parameter int CHAR_BITS = edc_pkg::DEF_CHAR_BITS
) (
   input wire logic  clock,
   input wire logic  reset,
   edc_req_if.sink   req_chan,
   edc_rsp_if.source rsp_chan
);
   import edc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer
   edc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_func  (req_chan.func),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // stores, dp cell and response register
   edc_datapath #(
      .MAX_LEN   (MAX_LEN),
      .CHAR_BITS (CHAR_BITS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .char_value   (req_chan.char_value),
      .rsp_valid    (rsp_chan.valid),
      .rsp_ready    (rsp_chan.ready),
      .rsp_distance (rsp_chan.distance),
      .rsp_too_long (rsp_chan.too_long)
   );

endmodule
`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the edit distance engine: source and target bytes
// are streamed in, each compute word is predicted by a local levenshtein
// sweep or carries a fixed answer, and the responses are compared in order,
// under random idling until the last third of the run, on both channels
// ----------------------------------------------------------------------------
module tb_top;
   import edc_pkg::*;

   localparam int STRING_CAP   = DEF_MAX_LEN;
   localparam int OVERRUN_LEN  = STRING_CAP + 8;
   localparam int ITEM_TARGET  = 1250;
   localparam int DRAIN_CYCLES = 16;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int SCRIPT_ROWS  = 22;

   // selector value with no function behind it
   localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

   typedef struct packed {
      logic [DIST_BITS-1:0] distance;
      logic                 too_long;
   } distance_word_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CHAR_W-1:0] char_value;
      logic              fixed_result;
      distance_word_type result;
   } script_row_type;

   // directed words; rows with fixed_result set carry their own answer
   localparam script_row_type DIRECTED_SCRIPT [SCRIPT_ROWS] = '{
      '{FUNC_RUN,  8'hff, 1'b1, '{7'd0, 1'b0}},   // both strings empty after reset
      '{FUNC_SRC,  8'h00, 1'b0, '{7'd0, 1'b0}},
      '{FUNC_RUN,  8'h00, 1'b1, '{7'd1, 1'b0}},   // one deletion
      '{FUNC_TGT,  8'hff, 1'b0, '{7'd0, 1'b0}},
      '{FUNC_RUN,  8'h00, 1'b1, '{7'd1, 1'b0}},   // one insertion
      '{FUNC_SRC,  8'hff, 1'b0, '{7'd0, 1'b0}},
      '{FUNC_TGT,  8'hff, 1'b0, '{7'd0, 1'b0}},
      '{FUNC_RUN,  8'h55, 1'b1, '{7'd0, 1'b0}},   // equal strings
      '{FUNC_SRC,  8'h00, 1'b0, '{7'd0, 1'b0}},
      '{FUNC_TGT,  8'h00, 1'b0, '{7'd0, 1'b0}},
      '{FUNC_RUN,  8'h00, 1'b1, '{7'd0, 1'b0}},   // zero byte is an ordinary byte
      '{FUNC_SRC,  8'h00, 1'b0, '{7'd0, 1'b0}},
      '{FUNC_TGT,  8'hff, 1'b0, '{7'd0, 1'b0}},
      '{FUNC_RUN,  8'h00, 1'b0, '{7'd0, 1'b0}},
      '{FUNC_NONE, 8'haa, 1'b0, '{7'd0, 1'b0}},   // unused selector, ignored
      '{FUNC_RUN,  8'h00, 1'b1, '{7'd0, 1'b0}},
      '{FUNC_SRC,  8'h55, 1'b0, '{7'd0, 1'b0}},
      '{FUNC_SRC,  8'haa, 1'b0, '{7'd0, 1'b0}},
      '{FUNC_TGT,  8'haa, 1'b0, '{7'd0, 1'b0}},
      '{FUNC_TGT,  8'h55, 1'b0, '{7'd0, 1'b0}},
      '{FUNC_NONE, 8'hff, 1'b0, '{7'd0, 1'b0}},
      '{FUNC_RUN,  8'hff, 1'b0, '{7'd0, 1'b0}}
   };

   logic clock;
   logic reset;

   edc_req_if req_chan ();
   edc_rsp_if rsp_chan ();

   edit_distance_engine_core #(
      .MAX_LEN   (STRING_CAP),
      .CHAR_BITS (DEF_CHAR_BITS)
   ) u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // predictor state: strings as loaded so far and the dropped-byte mark
   logic [CHAR_W-1:0] source_text [$];
   logic [CHAR_W-1:0] target_text [$];
   logic              dropped_char;
   distance_word_type pending_results [$];
   logic [CHAR_W-1:0] alphabet [4];

   int error_count;
   int words_issued;
   int cycle_count;
   int sender_idle_pct;
   int receiver_idle_pct;

   initial begin
      clock = 1'b0;
   end

   always begin
      #2 clock = ~clock;
   end

   // single row sweep over the loaded strings
   function automatic logic [DIST_BITS-1:0] predict_distance();
      int cost_row [STRING_CAP + 1];
      int diag;
      int up;
      int best;
      int i;
      int j;
      for (j = 0; j <= target_text.size(); j++) cost_row[j] = j;
      for (i = 1; i <= source_text.size(); i++) begin
         diag = cost_row[0];
         cost_row[0] = i;
         for (j = 1; j <= target_text.size(); j++) begin
            up = cost_row[j];
            if (source_text[i-1] == target_text[j-1]) begin
               cost_row[j] = diag;
            end else begin
               best = diag;
               if (cost_row[j-1] < best) best = cost_row[j-1];
               if (up < best) best = up;
               cost_row[j] = best + 1;
            end
            diag = up;
         end
      end
      best = cost_row[target_text.size()];
      if (best > DIST_MAX) best = DIST_MAX;
      return best[DIST_BITS-1:0];
   endfunction

   function automatic int pick_length(input int size_mode);
      if (size_mode < 75) return $urandom_range(8);
      if (size_mode < 95) return $urandom_range(24);
      return $urandom_range(OVERRUN_LEN, STRING_CAP - 24);
   endfunction

   function automatic logic [CHAR_W-1:0] pick_char(input logic narrow);
      if (narrow) return alphabet[$urandom_range(3)];
      return CHAR_W'($urandom_range(255));
   endfunction

   // present one word, wait for it to be taken, then advance the predictor
   task automatic issue_word(input logic [FUNC_W-1:0] f, input logic [CHAR_W-1:0] c,
                             input logic fixed, input distance_word_type fixed_word);
      distance_word_type outcome;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.func       <= f;
      req_chan.char_value <= c;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      case (f)
         FUNC_SRC: begin
            if (source_text.size() < STRING_CAP) source_text.push_back(c);
            else dropped_char = 1'b1;
         end
         FUNC_TGT: begin
            if (target_text.size() < STRING_CAP) target_text.push_back(c);
            else dropped_char = 1'b1;
         end
         FUNC_RUN: begin
            outcome.distance = predict_distance();
            outcome.too_long = dropped_char;
            pending_results.push_back(fixed ? fixed_word : outcome);
            source_text.delete();
            target_text.delete();
            dropped_char = 1'b0;
         end
         default: begin
         end
      endcase
      if (f != FUNC_NONE) words_issued++;
   endtask

   // response side: random back-pressure and in-order comparison
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result, expected none, got distance %0d too_long %0b",
                        $time, rsp_chan.distance, rsp_chan.too_long);
               error_count++;
            end else begin
               if (rsp_chan.distance !== pending_results[0].distance) begin
                  $display("%0t: distance mismatch, expected %0d, got %0d",
                           $time, pending_results[0].distance, rsp_chan.distance);
                  error_count++;
               end
               if (rsp_chan.too_long !== pending_results[0].too_long) begin
                  $display("%0t: too_long mismatch, expected %0b, got %0b",
                           $time, pending_results[0].too_long, rsp_chan.too_long);
                  error_count++;
               end
               void'(pending_results.pop_front());
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   // watchdog
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // stimulus
   initial begin
      logic [CHAR_W-1:0] src_seq [$];
      logic [CHAR_W-1:0] tgt_seq [$];
      int                size_mode;
      int                src_len;
      int                tgt_len;
      int                roll;
      int                k;
      logic              narrow;

      reset               = 1'b1;
      req_chan.valid      = 1'b0;
      req_chan.func       = FUNC_SRC;
      req_chan.char_value = '0;
      dropped_char        = 1'b0;
      error_count         = 0;
      words_issued        = 0;
      sender_idle_pct     = 37;
      receiver_idle_pct   = 79;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      for (k = 0; k < SCRIPT_ROWS; k++) begin
         issue_word(DIRECTED_SCRIPT[k].func, DIRECTED_SCRIPT[k].char_value,
                    DIRECTED_SCRIPT[k].fixed_result, DIRECTED_SCRIPT[k].result);
      end

      // full strings: the extra bytes are dropped and flagged, then the flag clears
      for (k = 0; k < STRING_CAP + 2; k++)
         issue_word(FUNC_SRC, CHAR_W'($urandom_range(255)), 1'b0, '0);
      for (k = 0; k < STRING_CAP + 2; k++)
         issue_word(FUNC_TGT, CHAR_W'($urandom_range(255)), 1'b0, '0);
      issue_word(FUNC_RUN, 8'h00, 1'b0, '0);
      issue_word(FUNC_RUN, 8'h00, 1'b1, '{7'd0, 1'b0});

      // random string pairs
      while (words_issued < ITEM_TARGET) begin
         // idling scheme follows progress through the run
         if (words_issued >= 2 * ITEM_TARGET / 3) begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end else if (words_issued >= ITEM_TARGET / 3) begin
            sender_idle_pct   = 79;
            receiver_idle_pct = 37;
         end

         size_mode = $urandom_range(99);
         src_len   = pick_length(size_mode);
         narrow    = 1'($urandom_range(1));
         for (k = 0; k < 4; k++) alphabet[k] = CHAR_W'($urandom_range(255));
         src_seq.delete();
         tgt_seq.delete();
         for (k = 0; k < src_len; k++) src_seq.push_back(pick_char(narrow));

         if ($urandom_range(1)) begin
            // target as an edited copy: delete, substitute, insert or keep
            foreach (src_seq[k]) begin
               roll = $urandom_range(9);
               if (tgt_seq.size() < OVERRUN_LEN) begin
                  if (roll == 1 || roll == 2) tgt_seq.push_back(pick_char(narrow));
                  if (roll >= 2) tgt_seq.push_back(src_seq[k]);
               end
            end
         end else begin
            tgt_len = pick_length(size_mode);
            for (k = 0; k < tgt_len; k++) tgt_seq.push_back(pick_char(narrow));
         end

         // interleave the two strings, with the odd unused selector word
         while (src_seq.size() + tgt_seq.size() != 0) begin
            if ($urandom_range(29) == 0)
               issue_word(FUNC_NONE, CHAR_W'($urandom_range(255)), 1'b0, '0);
            if (tgt_seq.size() == 0 || (src_seq.size() != 0 && $urandom_range(1)))
               issue_word(FUNC_SRC, src_seq.pop_front(), 1'b0, '0);
            else
               issue_word(FUNC_TGT, tgt_seq.pop_front(), 1'b0, '0);
         end

         // now and then the strings carry over into the next pair
         if ($urandom_range(24) != 0)
            issue_word(FUNC_RUN, CHAR_W'($urandom_range(255)), 1'b0, '0);
      end

      req_chan.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
